// ===== src/frpp_pkg.sv =====
package frpp_pkg;

    localparam int CFG_WIDTH = 16;
    localparam logic [CFG_WIDTH-1:0] MAX_PACKET_RESET = 16'd4096;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_SET_HEADER = 3'd1;
    localparam logic [2:0] KIND_NAME = 3'd2;
    localparam logic [2:0] KIND_ADDRESS = 3'd3;
    localparam logic [2:0] KIND_STATS = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    localparam logic [31:0] ERR_EARLY_END = 32'd0;
    localparam logic [31:0] ERR_NAME_OVERRUN = 32'd1;
    localparam logic [31:0] ERR_OVERSIZE = 32'd2;

    // one classified packet byte as it travels through the queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
        logic       oversize;
    } token_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic        last_of_run;
        logic [7:0]  version;
        logic [7:0]  set_total;
        logic [15:0] flags;
        logic [31:0] packet_sequence;
        logic [7:0]  name_total;
        logic [7:0]  address_total;
        logic [15:0] names_region_length;
        logic [7:0]  set_index;
        logic [7:0]  item_index;
        logic [31:0] value;
    } record_t;

endpackage

// ===== src/frpp_front.sv =====
module frpp_front #(
    parameter int PACKET_LENGTH_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [frpp_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    input  logic                          end_of_packet,
    input  logic                          queue_full,
    output logic                          queue_push,
    output frpp_pkg::token_t              queue_token
);

    localparam logic [PACKET_LENGTH_BITS-1:0] COUNT_CAP = '1;

    logic [frpp_pkg::CFG_WIDTH-1:0] max_bytes_reg;
    logic [PACKET_LENGTH_BITS-1:0]  byte_count_reg;
    logic [PACKET_LENGTH_BITS-1:0]  byte_count_next;
    logic                           accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign queue_push = accept;

    // flag a byte whose position lies beyond the limit or the counter's reach
    always_comb
    begin
        queue_token.data_byte     = data_byte;
        queue_token.end_of_packet = end_of_packet;
        queue_token.oversize      = (frpp_pkg::CFG_WIDTH'(byte_count_reg) >= max_bytes_reg)
                                    || (byte_count_reg == COUNT_CAP);
        if (end_of_packet)
            byte_count_next = '0;
        else if (byte_count_reg != COUNT_CAP)
            byte_count_next = byte_count_reg + 1'b1;
        else
            byte_count_next = byte_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg  <= frpp_pkg::MAX_PACKET_RESET;
            byte_count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                max_bytes_reg <= cfg_data;
            if (accept)
                byte_count_reg <= byte_count_next;
        end
    end

endmodule

// ===== src/frpp_queue.sv =====
module frpp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  frpp_pkg::token_t    push_token,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output frpp_pkg::token_t    head_token
);

    frpp_pkg::token_t                    mem [frpp_pkg::QUEUE_DEPTH];
    logic [frpp_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [frpp_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [frpp_pkg::QUEUE_CNT_BITS-1:0] count_reg;

    assign full  = (count_reg == frpp_pkg::QUEUE_CNT_BITS'(frpp_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head_token = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_token;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== src/frpp_back.sv =====
module frpp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                queue_empty,
    input  frpp_pkg::token_t    head_token,
    output logic                queue_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output frpp_pkg::record_t   out_record
);

    typedef enum logic [2:0] {
        PH_HDR,
        PH_STATS,
        PH_SETHDR,
        PH_NAMES,
        PH_SLACK,
        PH_ADDRS,
        PH_DONE,
        PH_ERR
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] fbc;
        logic [31:0] aw;
        logic [7:0]  ver;
        logic [7:0]  sets;
        logic [15:0] flags;
        logic [31:0] seq;
        logic [7:0]  cset;
        logic [7:0]  names;
        logic [7:0]  addrs;
        logic [15:0] srl;
        logic [7:0]  citem;
        logic [15:0] cnl;
    } parse_st_t;

    function automatic parse_st_t start_set(parse_st_t s);
        parse_st_t r;
        r = s;
        r.phase = PH_SETHDR;
        r.fbc = '0;
        r.aw = '0;
        r.names = '0;
        r.addrs = '0;
        r.srl = '0;
        r.citem = '0;
        r.cnl = '0;
        return r;
    endfunction

    function automatic parse_st_t next_set(parse_st_t s);
        parse_st_t r;
        r = s;
        r.cset = s.cset + 8'd1;
        if (r.cset >= r.sets)
            r.phase = PH_DONE;
        else
            r = start_set(r);
        return r;
    endfunction

    function automatic parse_st_t begin_addresses(parse_st_t s);
        parse_st_t r;
        r = s;
        r.fbc = '0;
        r.aw = '0;
        r.citem = '0;
        if (r.addrs != 8'd0)
            r.phase = PH_ADDRS;
        else
            r = next_set(r);
        return r;
    endfunction

    function automatic frpp_pkg::record_t make_rec(logic [2:0] kind, logic with_set,
                                                   logic [7:0] item, logic [31:0] val,
                                                   parse_st_t s);
        frpp_pkg::record_t r;
        r.record_kind         = kind;
        r.last_of_run         = 1'b0;
        r.version             = s.ver;
        r.set_total           = s.sets;
        r.flags               = s.flags;
        r.packet_sequence     = s.seq;
        r.name_total          = with_set ? s.names : 8'd0;
        r.address_total       = with_set ? s.addrs : 8'd0;
        r.names_region_length = with_set ? s.srl : 16'd0;
        r.set_index           = with_set ? s.cset : 8'd0;
        r.item_index          = item;
        r.value               = val;
        return r;
    endfunction

    parse_st_t         st_reg;
    parse_st_t         s;
    frpp_pkg::record_t rec0;
    frpp_pkg::record_t rec1;
    frpp_pkg::record_t rec;
    logic [1:0]        n;
    logic [7:0]        b;
    logic              out_free;

    logic              out_valid_reg;
    frpp_pkg::record_t out_rec_reg;
    logic              pend_valid_reg;
    frpp_pkg::record_t pend_rec_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign queue_pop = !queue_empty && !pend_valid_reg && out_free;
    assign out_valid = out_valid_reg;
    assign out_record = out_rec_reg;

    // one byte step: next parse state and up to two records
    always_comb
    begin
        s = st_reg;
        b = head_token.data_byte;
        n = 2'd0;
        rec0 = '0;
        rec1 = '0;
        rec = '0;
        if (s.phase != PH_ERR)
        begin
            if (head_token.oversize)
            begin
                rec = make_rec(frpp_pkg::KIND_ERROR, 1'b0, 8'd0, frpp_pkg::ERR_OVERSIZE, s);
                rec0 = rec;
                n = 2'd1;
                s.phase = PH_ERR;
            end
            else
            begin
                unique case (s.phase)
                    PH_HDR:
                    begin
                        if (s.fbc == 16'd0)
                            s.ver = b;
                        else if (s.fbc == 16'd1)
                            s.sets = b;
                        else if (s.fbc < 16'd4)
                            s.flags = {s.flags[7:0], b};
                        else
                            s.seq = {s.seq[23:0], b};
                        s.fbc = s.fbc + 16'd1;
                        if (s.fbc == 16'd8)
                        begin
                            rec0 = make_rec(frpp_pkg::KIND_HEADER, 1'b0, 8'd0, 32'd0, s);
                            n = 2'd1;
                            s.fbc = '0;
                            s.aw = '0;
                            s.citem = '0;
                            if (s.flags != 16'd0)
                                s.phase = PH_STATS;
                            else if (s.sets == 8'd0)
                                s.phase = PH_DONE;
                            else
                            begin
                                s.cset = '0;
                                s = start_set(s);
                            end
                        end
                    end
                    PH_STATS:
                    begin
                        s.aw = {s.aw[23:0], b};
                        s.fbc = s.fbc + 16'd1;
                        if (s.fbc == 16'd4)
                        begin
                            rec0 = make_rec(frpp_pkg::KIND_STATS, 1'b0, s.citem, s.aw, s);
                            n = 2'd1;
                            s.fbc = '0;
                            s.aw = '0;
                            s.citem = s.citem + 8'd1;
                            if (s.citem >= 8'd4)
                                s.phase = PH_DONE;
                        end
                    end
                    PH_SETHDR:
                    begin
                        if (s.fbc < 16'd4)
                            s.aw = {s.aw[23:0], b};
                        else if (s.fbc == 16'd4)
                            s.names = b;
                        else if (s.fbc == 16'd5)
                            s.addrs = b;
                        else
                            s.srl = {s.srl[7:0], b};
                        s.fbc = s.fbc + 16'd1;
                        if (s.fbc == 16'd8)
                        begin
                            rec0 = make_rec(frpp_pkg::KIND_SET_HEADER, 1'b1, 8'd0, s.aw, s);
                            n = 2'd1;
                            s.fbc = '0;
                            s.citem = '0;
                            s.cnl = '0;
                            if (s.names != 8'd0)
                            begin
                                if (s.srl == 16'd0)
                                begin
                                    rec1 = make_rec(frpp_pkg::KIND_ERROR, 1'b0, 8'd0,
                                                    frpp_pkg::ERR_NAME_OVERRUN, s);
                                    n = 2'd2;
                                    s.phase = PH_ERR;
                                end
                                else
                                    s.phase = PH_NAMES;
                            end
                            else if (s.srl != 16'd0)
                                s.phase = PH_SLACK;
                            else
                                s = begin_addresses(s);
                        end
                    end
                    PH_NAMES:
                    begin
                        s.fbc = s.fbc + 16'd1;
                        if (b == 8'd0)
                        begin
                            rec0 = make_rec(frpp_pkg::KIND_NAME, 1'b1, s.citem,
                                            {16'd0, s.cnl}, s);
                            n = 2'd1;
                            s.citem = s.citem + 8'd1;
                            s.cnl = '0;
                        end
                        else
                            s.cnl = s.cnl + 16'd1;
                        if (b == 8'd0 && s.citem >= s.names)
                        begin
                            if (s.fbc >= s.srl)
                                s = begin_addresses(s);
                            else
                                s.phase = PH_SLACK;
                        end
                        else if (s.fbc >= s.srl)
                        begin
                            rec = make_rec(frpp_pkg::KIND_ERROR, 1'b0, 8'd0,
                                           frpp_pkg::ERR_NAME_OVERRUN, s);
                            if (n == 2'd0)
                                rec0 = rec;
                            else
                                rec1 = rec;
                            n = n + 2'd1;
                            s.phase = PH_ERR;
                        end
                    end
                    PH_SLACK:
                    begin
                        s.fbc = s.fbc + 16'd1;
                        if (s.fbc >= s.srl)
                            s = begin_addresses(s);
                    end
                    PH_ADDRS:
                    begin
                        s.aw = {s.aw[23:0], b};
                        s.fbc = s.fbc + 16'd1;
                        if (s.fbc == 16'd4)
                        begin
                            rec0 = make_rec(frpp_pkg::KIND_ADDRESS, 1'b1, s.citem, s.aw, s);
                            n = 2'd1;
                            s.fbc = '0;
                            s.aw = '0;
                            s.citem = s.citem + 8'd1;
                            if (s.citem >= s.addrs)
                                s = next_set(s);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        // early end: the packet closed before the parse finished
        if (head_token.end_of_packet)
        begin
            if (s.phase != PH_DONE && s.phase != PH_ERR)
            begin
                rec = make_rec(frpp_pkg::KIND_ERROR, 1'b0, 8'd0, frpp_pkg::ERR_EARLY_END, s);
                if (n == 2'd0)
                    rec0 = rec;
                else
                    rec1 = rec;
                n = n + 2'd1;
            end
            s = '0;
        end
        if (n == 2'd1)
            rec0.last_of_run = 1'b1;
        else if (n == 2'd2)
            rec1.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_rec_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_rec_reg   <= '0;
        end
        else if (pend_valid_reg)
        begin
            // drain the second record of a byte before taking another
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                out_rec_reg    <= pend_rec_reg;
                pend_valid_reg <= 1'b0;
            end
        end
        else if (queue_pop)
        begin
            st_reg <= s;
            if (n != 2'd0)
            begin
                out_valid_reg <= 1'b1;
                out_rec_reg   <= rec0;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
            pend_valid_reg <= (n == 2'd2);
            pend_rec_reg   <= rec1;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

endmodule

// ===== src/flow_record_packet_parser.sv =====
// Flow-record packet parser.
// Input channel (in_valid/in_ready, data_byte, end_of_packet) takes one packet
// byte per transaction; end_of_packet marks the final byte of each packet.
// Output channel (out_valid/out_ready plus one port per record field) delivers
// one decoded record per transaction; last_of_run flags the final record
// caused by a given byte.
// Config channel (cfg_valid/cfg_ready, cfg_data) writes max_packet_bytes; it is
// always ready and should be written only while the block is idle.
// Throughput: one byte per cycle while out_ready stays high. A byte that yields two
// records holds the parser while the second record drains.
// Path: a byte enters the 4-entry queue on acceptance, is parsed once it is at
// the head of the queue and the parser is free, and its first record is then
// registered in the output register.
// Stalls: when out_ready is low the output register holds its record, the
// parser stops and the queue absorbs up to four bytes before in_ready drops.
// Reset: rst_n (async, active low) empties the queue and output, returns the
// parser to awaiting a packet header and sets max_packet_bytes to 4096.
module flow_record_packet_parser #(
    parameter int PACKET_LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_packet,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  record_kind,
    output logic        last_of_run,
    output logic [7:0]  version,
    output logic [7:0]  set_total,
    output logic [15:0] flags,
    output logic [31:0] packet_sequence,
    output logic [7:0]  name_total,
    output logic [7:0]  address_total,
    output logic [15:0] names_region_length,
    output logic [7:0]  set_index,
    output logic [7:0]  item_index,
    output logic [31:0] value
);

    logic                queue_push;
    logic                queue_full;
    logic                queue_pop;
    logic                queue_empty;
    frpp_pkg::token_t    push_token;
    frpp_pkg::token_t    head_token;
    frpp_pkg::record_t   rec;

    // front: accept bytes, track packet position, flag oversize bytes
    frpp_front #(
        .PACKET_LENGTH_BITS(PACKET_LENGTH_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_packet(end_of_packet),
        .queue_full   (queue_full),
        .queue_push   (queue_push),
        .queue_token  (push_token)
    );

    // short queue decoupling the front from the parser
    frpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_token(push_token),
        .full      (queue_full),
        .pop       (queue_pop),
        .empty     (queue_empty),
        .head_token(head_token)
    );

    // back: parse each byte and deliver its records
    frpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .queue_empty(queue_empty),
        .head_token (head_token),
        .queue_pop  (queue_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_record (rec)
    );

    assign record_kind         = rec.record_kind;
    assign last_of_run         = rec.last_of_run;
    assign version             = rec.version;
    assign set_total           = rec.set_total;
    assign flags               = rec.flags;
    assign packet_sequence     = rec.packet_sequence;
    assign name_total          = rec.name_total;
    assign address_total       = rec.address_total;
    assign names_region_length = rec.names_region_length;
    assign set_index           = rec.set_index;
    assign item_index          = rec.item_index;
    assign value               = rec.value;

endmodule

// ===== tb/flow_record_packet_parser_tb.sv =====
module flow_record_packet_parser_tb;

    localparam int PACKET_LENGTH_BITS = 16;
    localparam logic [15:0] BYTE_COUNT_CAP = 16'((32'd1 << PACKET_LENGTH_BITS) - 1);
    localparam int CLK_PERIOD = 8;
    localparam int TIMEOUT_CYCLES = 200_000;
    // enough for the input queue, the parser and the output register to empty
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_BYTES = 650;
    localparam int RANDOM_PHASES = 5;

    // parser position within a packet, mirrored from the block's behavior
    typedef enum logic [2:0] {
        P_HEADER,
        P_STATS,
        P_SET_HEADER,
        P_NAMES,
        P_SLACK,
        P_ADDRS,
        P_DONE,
        P_ERROR
    } parse_phase_t;

    // how the record sink paces out_ready
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SLOW
    } rx_style_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_packet;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  record_kind;
    logic        last_of_run;
    logic [7:0]  version;
    logic [7:0]  set_total;
    logic [15:0] flags;
    logic [31:0] packet_sequence;
    logic [7:0]  name_total;
    logic [7:0]  address_total;
    logic [15:0] names_region_length;
    logic [7:0]  set_index;
    logic [7:0]  item_index;
    logic [31:0] value;

    flow_record_packet_parser #(
        .PACKET_LENGTH_BITS(PACKET_LENGTH_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .end_of_packet(end_of_packet),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .record_kind(record_kind),
        .last_of_run(last_of_run),
        .version(version),
        .set_total(set_total),
        .flags(flags),
        .packet_sequence(packet_sequence),
        .name_total(name_total),
        .address_total(address_total),
        .names_region_length(names_region_length),
        .set_index(set_index),
        .item_index(item_index),
        .value(value)
    );

    // Run-wide bookkeeping
    frpp_pkg::record_t due_records[$];     // decoded records not yet seen on the output
    frpp_pkg::record_t byte_records[$];    // records caused by the byte being decoded
    logic [7:0] packet_bytes[$];   // packet under construction
    int        error_count = 0;
    int        hold_request = 0;   // cycles the sink must still hold off
    int        burst_left = 0;
    bit        gaps_on = 1'b1;
    rx_style_t rx_style = RX_RANDOM;
    logic [2:0] rx_tick = 3'd0;

    // Decoder state kept alongside the block
    logic [15:0]  max_bytes;
    parse_phase_t pstate;
    logic [15:0]  field_count;
    logic [15:0]  pkt_count;
    logic [31:0]  word;
    logic [7:0]   m_version;
    logic [7:0]   m_sets;
    logic [15:0]  m_flags;
    logic [31:0]  m_sequence;
    logic [7:0]   m_set;
    logic [7:0]   m_names;
    logic [7:0]   m_addrs;
    logic [15:0]  m_region;
    logic [7:0]   m_item;
    logic [15:0]  m_name_len;

    // Clock: 8 time units, low then high
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------

    function automatic void clear_parse();
        pstate = P_HEADER;
        field_count = '0;
        pkt_count = '0;
        word = '0;
        m_version = '0;
        m_sets = '0;
        m_flags = '0;
        m_sequence = '0;
        m_set = '0;
        m_names = '0;
        m_addrs = '0;
        m_region = '0;
        m_item = '0;
        m_name_len = '0;
    endfunction

    // Build one record from the current header and set state; at most two per byte.
    function automatic void emit_record(logic [2:0] kind, bit with_set, logic [7:0] item,
                                        logic [31:0] val);
        frpp_pkg::record_t r;
        if (byte_records.size() >= 2)
            return;
        r.record_kind = kind;
        r.last_of_run = 1'b0;
        r.version = m_version;
        r.set_total = m_sets;
        r.flags = m_flags;
        r.packet_sequence = m_sequence;
        r.name_total = with_set ? m_names : 8'd0;
        r.address_total = with_set ? m_addrs : 8'd0;
        r.names_region_length = with_set ? m_region : 16'd0;
        r.set_index = with_set ? m_set : 8'd0;
        r.item_index = item;
        r.value = val;
        byte_records.push_back(r);
    endfunction

    function automatic void raise_error(logic [31:0] code);
        emit_record(frpp_pkg::KIND_ERROR, 1'b0, 8'd0, code);
        pstate = P_ERROR;
    endfunction

    function automatic void open_set();
        pstate = P_SET_HEADER;
        field_count = '0;
        word = '0;
        m_names = '0;
        m_addrs = '0;
        m_region = '0;
        m_item = '0;
        m_name_len = '0;
    endfunction

    function automatic void advance_set();
        m_set = m_set + 8'd1;
        if (m_set >= m_sets)
            pstate = P_DONE;
        else
            open_set();
    endfunction

    function automatic void open_addresses();
        field_count = '0;
        word = '0;
        m_item = '0;
        if (m_addrs > 0)
            pstate = P_ADDRS;
        else
            advance_set();
    endfunction

    // Advance the parse by one byte that is neither oversize nor after an error.
    function automatic void parse_byte(logic [7:0] b);
        bit names_done;
        names_done = 1'b0;
        case (pstate)
            P_HEADER:
            begin
                if (field_count == 0)
                    m_version = b;
                else if (field_count == 1)
                    m_sets = b;
                else if (field_count < 4)
                    m_flags = {m_flags[7:0], b};
                else
                    m_sequence = {m_sequence[23:0], b};
                field_count++;
                if (field_count == 8)
                begin
                    emit_record(frpp_pkg::KIND_HEADER, 1'b0, 8'd0, 32'd0);
                    field_count = '0;
                    word = '0;
                    m_item = '0;
                    // nonzero flags select stats, whatever the set count says
                    if (m_flags != 0)
                        pstate = P_STATS;
                    else if (m_sets == 0)
                        pstate = P_DONE;
                    else
                    begin
                        m_set = '0;
                        open_set();
                    end
                end
            end
            P_STATS:
            begin
                word = {word[23:0], b};
                field_count++;
                if (field_count == 4)
                begin
                    emit_record(frpp_pkg::KIND_STATS, 1'b0, m_item, word);
                    field_count = '0;
                    word = '0;
                    m_item++;
                    if (m_item >= 4)
                        pstate = P_DONE;
                end
            end
            P_SET_HEADER:
            begin
                if (field_count < 4)
                    word = {word[23:0], b};
                else if (field_count == 4)
                    m_names = b;
                else if (field_count == 5)
                    m_addrs = b;
                else
                    m_region = {m_region[7:0], b};
                field_count++;
                if (field_count == 8)
                begin
                    emit_record(frpp_pkg::KIND_SET_HEADER, 1'b1, 8'd0, word);
                    field_count = '0;
                    m_item = '0;
                    m_name_len = '0;
                    if (m_names != 0)
                    begin
                        // names announced but no room for them
                        if (m_region == 0)
                            raise_error(frpp_pkg::ERR_NAME_OVERRUN);
                        else
                            pstate = P_NAMES;
                    end
                    else if (m_region != 0)
                        pstate = P_SLACK;
                    else
                        open_addresses();
                end
            end
            P_NAMES:
            begin
                field_count++;
                if (b == 8'd0)
                begin
                    emit_record(frpp_pkg::KIND_NAME, 1'b1, m_item, {16'd0, m_name_len});
                    m_item = m_item + 8'd1;
                    m_name_len = '0;
                    if (m_item >= m_names)
                    begin
                        names_done = 1'b1;
                        if (field_count >= m_region)
                            open_addresses();
                        else
                            pstate = P_SLACK;
                    end
                end
                else
                    m_name_len = m_name_len + 16'd1;
                // region used up while names are still owed
                if (!names_done && field_count >= m_region)
                    raise_error(frpp_pkg::ERR_NAME_OVERRUN);
            end
            P_SLACK:
            begin
                field_count++;
                if (field_count >= m_region)
                    open_addresses();
            end
            P_ADDRS:
            begin
                word = {word[23:0], b};
                field_count++;
                if (field_count == 4)
                begin
                    emit_record(frpp_pkg::KIND_ADDRESS, 1'b1, m_item, word);
                    field_count = '0;
                    word = '0;
                    m_item = m_item + 8'd1;
                    if (m_item >= m_addrs)
                        advance_set();
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Work out the records one accepted byte causes and queue them up.
    function automatic void predict_byte_records(logic [7:0] b, logic eop);
        frpp_pkg::record_t r;
        byte_records.delete();
        if (pstate != P_ERROR)
        begin
            if (pkt_count >= max_bytes || pkt_count >= BYTE_COUNT_CAP)
                raise_error(frpp_pkg::ERR_OVERSIZE);
            else
                parse_byte(b);
        end
        if (pkt_count < BYTE_COUNT_CAP)
            pkt_count++;
        if (eop)
        begin
            if (pstate != P_DONE && pstate != P_ERROR)
                raise_error(frpp_pkg::ERR_EARLY_END);
            clear_parse();
        end
        if (byte_records.size() > 0)
        begin
            r = byte_records.pop_back();
            r.last_of_run = 1'b1;
            byte_records.push_back(r);
        end
        foreach (byte_records[k])
            due_records.push_back(byte_records[k]);
    endfunction

    // ------------------------------------------------------------------
    // Record sink: pace out_ready and check every output transaction
    // ------------------------------------------------------------------

    // Hold off for a requested stretch first, otherwise follow the current style.
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            out_ready <= 1'b0;
            hold_request = hold_request - 1;
        end
        else
        begin
            case (rx_style)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_RANDOM: out_ready <= ($urandom_range(0, 9) < 6);
                RX_PATTERN: out_ready <= (rx_tick != 3'd2 && rx_tick != 3'd5 && rx_tick != 3'd6);
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
        rx_tick <= rx_tick + 3'd1;
    end

    task automatic compare_field(string field_name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, got);
            error_count++;
        end
    endtask

    // Match each output transaction against the oldest decoded record.
    always @(posedge clk)
    begin : check_records
        frpp_pkg::record_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_records.size() == 0)
            begin
                $display("%0t: record with none expected, actual kind %0d value 0x%0h",
                         $time, record_kind, value);
                error_count++;
            end
            else
            begin
                want = due_records.pop_front();
                compare_field("record_kind", 32'(want.record_kind), 32'(record_kind));
                compare_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
                compare_field("version", 32'(want.version), 32'(version));
                compare_field("set_total", 32'(want.set_total), 32'(set_total));
                compare_field("flags", 32'(want.flags), 32'(flags));
                compare_field("packet_sequence", want.packet_sequence, packet_sequence);
                compare_field("name_total", 32'(want.name_total), 32'(name_total));
                compare_field("address_total", 32'(want.address_total),
                              32'(address_total));
                compare_field("names_region_length", 32'(want.names_region_length),
                              32'(names_region_length));
                compare_field("set_index", 32'(want.set_index), 32'(set_index));
                compare_field("item_index", 32'(want.item_index), 32'(item_index));
                compare_field("value", want.value, value);
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------

    // Offer one byte from a falling edge, hold it until the transaction completes,
    // and return on the next falling edge with valid still high.
    task automatic send_byte(logic [7:0] b, logic eop);
        if (gaps_on && burst_left == 0)
        begin
            // drop valid for a gap, then start a fresh burst
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        end_of_packet <= eop;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte_records(b, eop);
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
    endtask

    task automatic send_packet();
        for (int k = 0; k < packet_bytes.size(); k++)
            send_byte(packet_bytes[k], k == packet_bytes.size() - 1);
        packet_bytes.delete();
    endtask

    // Drop valid and wait until every decoded record has drained, plus the
    // cycles a byte that causes nothing may still spend inside the block.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (due_records.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write max_packet_bytes once the block is idle.
    task automatic write_max_bytes(logic [15:0] limit);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        max_bytes = limit;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Packet builders
    // ------------------------------------------------------------------

    function automatic void put_byte(logic [7:0] b);
        packet_bytes.push_back(b);
    endfunction

    function automatic void put_word(logic [31:0] w);
        put_byte(w[31:24]);
        put_byte(w[23:16]);
        put_byte(w[15:8]);
        put_byte(w[7:0]);
    endfunction

    function automatic void put_header(logic [7:0] ver, logic [7:0] sets, logic [15:0] flg,
                                       logic [31:0] seq);
        put_byte(ver);
        put_byte(sets);
        put_byte(flg[15:8]);
        put_byte(flg[7:0]);
        put_word(seq);
    endfunction

    // Append one set with random name lengths up to max_len; trim shortens the
    // announced region, which can leave too little room for the names.
    function automatic void put_set(logic [31:0] client, int n_names, int n_addrs, int slack,
                                    int max_len, int trim);
        int lens[$];
        int region;
        region = slack;
        for (int k = 0; k < n_names; k++)
        begin
            lens.push_back(int'($urandom_range(0, max_len)));
            region += lens[k] + 1;
        end
        region = (region > trim) ? region - trim : 0;
        put_word(client);
        put_byte(8'(n_names));
        put_byte(8'(n_addrs));
        put_byte(8'(region >> 8));
        put_byte(8'(region));
        foreach (lens[k])
        begin
            repeat (lens[k]) put_byte(8'($urandom_range(1, 255)));
            put_byte(8'd0);
        end
        repeat (slack) put_byte(8'($urandom));
        repeat (n_addrs) put_word($urandom);
    endfunction

    // Mostly well-formed data and stats packets, some damaged, some pure noise.
    function automatic void build_random_packet();
        int pick;
        int damage;
        int cut;
        int n_sets;
        pick = $urandom_range(0, 99);
        if (pick < 14)
        begin
            put_header(8'($urandom), 8'($urandom), 16'($urandom_range(1, 16'hFFFF)), $urandom);
            repeat (4) put_word($urandom);
        end
        else if (pick < 92)
        begin
            n_sets = $urandom_range(0, 3);
            put_header(8'($urandom), 8'(n_sets), 16'd0, $urandom);
            repeat (n_sets)
                put_set($urandom, $urandom_range(0, 4), $urandom_range(0, 3),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0, 6,
                        ($urandom_range(0, 11) == 0) ? $urandom_range(1, 3) : 0);
        end
        else
        begin
            repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
            return;
        end
        damage = $urandom_range(0, 99);
        if (damage < 8)
        begin
            // end the packet early
            cut = $urandom_range(1, packet_bytes.size());
            while (packet_bytes.size() > cut)
                void'(packet_bytes.pop_back());
        end
        else if (damage < 14)
            packet_bytes[$urandom_range(0, packet_bytes.size() - 1)] = 8'($urandom);
        else if (damage < 32)
            repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_header_only();
        rx_style = RX_RANDOM;
        gaps_on = 1'b1;
        // a data packet with zero sets is complete after its header
        put_header(8'hFF, 8'd0, 16'd0, 32'hFFFF_FFFF);
        send_packet();
        put_header(8'h00, 8'd0, 16'd0, 32'h0000_0000);
        send_packet();
    endtask

    task automatic test_stats_packet();
        rx_style = RX_PATTERN;
        // set count is reported but the four counters follow regardless
        put_header(8'h02, 8'h07, 16'h8000, 32'h0123_4567);
        put_word(32'h0000_0000);
        put_word(32'hFFFF_FFFF);
        put_word(32'h8000_0001);
        put_word(32'h5A5A_A5A5);
        send_packet();
        // stop after two counters
        put_header(8'h02, 8'h00, 16'h0001, 32'h89AB_CDEF);
        put_word(32'h1111_1111);
        put_word(32'h2222_2222);
        send_packet();
    endtask

    task automatic test_data_sets();
        rx_style = RX_ALWAYS;
        gaps_on = 1'b0;
        // names with slack, addresses only, and a set of pure slack
        put_header(8'h01, 8'd3, 16'd0, 32'hCAFE_0001);
        put_set(32'hFFFF_FFFF, 2, 2, 2, 5, 0);
        put_set(32'h0000_0000, 0, 1, 0, 0, 0);
        put_set(32'h0A00_0001, 0, 0, 3, 0, 0);
        send_packet();
        gaps_on = 1'b1;
        rx_style = RX_RANDOM;
        // empty names that fill the region exactly, then no addresses
        put_header(8'h01, 8'd2, 16'd0, 32'hCAFE_0002);
        put_set(32'hC0A8_0101, 3, 0, 0, 0, 0);
        put_set(32'hC0A8_0102, 1, 1, 0, 4, 0);
        send_packet();
    endtask

    task automatic test_name_overrun();
        rx_style = RX_SLOW;
        // names announced with a zero-length region, then ignored bytes
        put_header(8'h01, 8'd1, 16'd0, 32'h0000_0010);
        put_word(32'h0102_0304);
        put_byte(8'd2);
        put_byte(8'd1);
        put_byte(8'd0);
        put_byte(8'd0);
        put_word(32'hDEAD_BEEF);
        send_packet();
        // region runs out in the middle of a name
        put_header(8'h01, 8'd1, 16'd0, 32'h0000_0011);
        put_word(32'h0506_0708);
        put_byte(8'd1);
        put_byte(8'd0);
        put_byte(8'd0);
        put_byte(8'd3);
        put_byte(8'h41);
        put_byte(8'h42);
        put_byte(8'h43);
        put_byte(8'h44);
        put_byte(8'h00);
        send_packet();
    endtask

    task automatic test_early_end();
        rx_style = RX_RANDOM;
        // one-byte packet
        put_byte(8'h5A);
        send_packet();
        // header cut short
        put_header(8'h03, 8'd1, 16'd0, 32'h1234_5678);
        repeat (3) void'(packet_bytes.pop_back());
        send_packet();
        // a huge names region ends with the packet
        put_header(8'h03, 8'd1, 16'd0, 32'h1234_5679);
        put_word(32'h7F00_0001);
        put_byte(8'd1);
        put_byte(8'd0);
        put_byte(8'hFF);
        put_byte(8'hFF);
        repeat (4) put_byte(8'h61);
        send_packet();
        // all sets announced, only one delivered
        put_header(8'h03, 8'd255, 16'd0, 32'h1234_567A);
        put_set(32'h0102_0304, 1, 1, 1, 3, 0);
        send_packet();
    endtask

    task automatic test_trailing_bytes();
        rx_style = RX_PATTERN;
        put_header(8'h04, 8'd0, 16'd0, 32'h0BAD_F00D);
        repeat (5) put_byte(8'($urandom));
        send_packet();
        put_header(8'h04, 8'd9, 16'hFFFF, 32'h0BAD_F00E);
        repeat (4) put_word($urandom);
        put_byte(8'hFF);
        put_byte(8'h00);
        send_packet();
    endtask

    task automatic test_count_extremes();
        rx_style = RX_RANDOM;
        gaps_on = 1'b1;
        // most names a set can announce, all of them empty, then a few addresses
        put_header(8'h05, 8'd1, 16'd0, 32'h8000_0000);
        put_set($urandom, 255, 6, 0, 0, 0);
        send_packet();
        // a long run of empty sets
        rx_style = RX_ALWAYS;
        gaps_on = 1'b0;
        put_header(8'h05, 8'd20, 16'd0, 32'h8000_0001);
        repeat (20) put_set($urandom, 0, 0, 0, 0, 0);
        send_packet();
    endtask

    task automatic test_oversize();
        gaps_on = 1'b1;
        rx_style = RX_RANDOM;
        write_max_bytes(16'd8);
        // a header that fits exactly, then one that is followed by more
        put_header(8'h06, 8'd0, 16'd0, 32'h0000_0001);
        send_packet();
        put_header(8'h06, 8'd1, 16'd0, 32'h0000_0002);
        put_set(32'h0A0A_0A0A, 1, 1, 0, 2, 0);
        send_packet();
        write_max_bytes(16'd12);
        put_header(8'h06, 8'd1, 16'd0, 32'h0000_0003);
        put_set(32'h0B0B_0B0B, 0, 2, 0, 0, 0);
        send_packet();
        // ends exactly at the limit, inside a set header: early end, not oversize
        put_header(8'h06, 8'd1, 16'd0, 32'h0000_0004);
        repeat (4) put_byte(8'h00);
        send_packet();
        write_max_bytes(frpp_pkg::MAX_PACKET_RESET);
    endtask

    // Hold the sink off long enough that the input queue fills and in_ready drops.
    task automatic test_backpressure();
        rx_style = RX_ALWAYS;
        gaps_on = 1'b0;
        hold_request = 150;
        repeat (3)
        begin
            put_header(8'h07, 8'd1, 16'd0, $urandom);
            put_set($urandom, 2, 2, 1, 3, 0);
            send_packet();
        end
        wait_until_drained();
    endtask

    task automatic test_random_traffic();
        int sent;
        logic [15:0] limit;
        sent = 0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: limit = frpp_pkg::MAX_PACKET_RESET;
                1: limit = 16'($urandom_range(24, 160));
                2: limit = 16'd8;
                3: limit = 16'($urandom_range(200, 1000));
                default: limit = 16'hFFFF;
            endcase
            write_max_bytes(limit);
            while (sent < (ph + 1) * RANDOM_BYTES / RANDOM_PHASES)
            begin
                // change pacing now and then, leaving some stretches with no idling
                rx_style = rx_style_t'($urandom_range(0, 3));
                gaps_on = ($urandom_range(0, 3) != 0);
                build_random_packet();
                sent += packet_bytes.size();
                send_packet();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        end_of_packet = 1'b0;
        max_bytes = frpp_pkg::MAX_PACKET_RESET;
        clear_parse();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_header_only();
        test_stats_packet();
        test_data_sets();
        test_name_overrun();
        test_early_end();
        test_trailing_bytes();
        test_count_extremes();
        test_oversize();
        test_backpressure();
        test_random_traffic();

        wait_until_drained();
        if (error_count == 0 && due_records.size() == 0)
            $display("flow_record_packet_parser_tb: PASS");
        else
            $display("flow_record_packet_parser_tb: FAIL");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("flow_record_packet_parser_tb: FAIL");
        $finish;
    end

endmodule
